### hw/rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg: shared types and constants of the periodic bond angle core
// Sideband structs, register codes, fixed-point limits, arctangent table.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_BOX_LENGTH    = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_BOND_SQ_LIMIT = 8'd1;

  localparam logic [31:0] BOX_RESET   = 32'd817583;
  localparam logic [31:0] LIMIT_RESET = 32'd131072;

  localparam logic [17:0] LEN_SAT   = 18'd131072;
  localparam logic [23:0] ANGLE_MAX = 24'd11796480;
  localparam logic [25:0] ROT90     = 26'd5898240;   // 90 deg in Q16

  localparam int unsigned CordicSteps = 18;

  // per-bond result fields plus the "angle is zero" flag
  typedef struct packed {
    logic        kill;
    logic [17:0] first_len;
    logic [17:0] second_len;
    logic        first_found;
    logic        second_found;
  } res_side_t;

  // carried alongside the cross-product root
  typedef struct packed {
    logic signed [33:0] dot;
    res_side_t          res;
  } ang_side_t;

  // carried alongside the first bond length root
  typedef struct packed {
    logic             first_found;
    logic [2:0][25:0] first_vec;
    logic [2:0][25:0] second_vec;
  } len_side_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic [21:0] atan_deg(input int unsigned step);
    case (step)
      0:       return 22'd2949120;
      1:       return 22'd1740967;
      2:       return 22'd919879;
      3:       return 22'd466945;
      4:       return 22'd234379;
      5:       return 22'd117304;
      6:       return 22'd58666;
      7:       return 22'd29335;
      8:       return 22'd14668;
      9:       return 22'd7334;
      10:      return 22'd3667;
      11:      return 22'd1833;
      12:      return 22'd917;
      13:      return 22'd458;
      14:      return 22'd229;
      15:      return 22'd115;
      16:      return 22'd57;
      17:      return 22'd29;
      default: return 22'd0;
    endcase
  endfunction

endpackage

### hw/rtl/pba_isqrt.sv
// ----------------------------------------------------------------------------
// pba_isqrt: pipelined integer square root
// One result bit per register stage; floor root and remainder, with sideband.
// ----------------------------------------------------------------------------
module pba_isqrt #(
  parameter int unsigned RAD_W  = 48,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [RAD_W-1:0]       rad_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [RAD_W/2-1:0]     root_o,
  output logic [RAD_W/2+1:0]     rem_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int unsigned ResW = RAD_W / 2;
  localparam int unsigned RemW = ResW + 3;

  logic              vld_q  [ResW];
  logic [RAD_W-1:0]  rad_q  [ResW];
  logic [RemW-1:0]   rem_q  [ResW];
  logic [ResW-1:0]   root_q [ResW];
  logic [SIDE_W-1:0] side_q [ResW];

  for (genvar s = 0; s < ResW; s++) begin : g_stage
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [RemW-1:0]   rem_in;
    logic [ResW-1:0]   root_in;
    logic [SIDE_W-1:0] side_in;
    logic [RemW-1:0]   rem_cur;
    logic [RemW-1:0]   trial;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // bring down the next two radicand bits
    assign rem_cur = {rem_in[RemW-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_in << 2;
      side_q[s] <= side_in;
      if (rem_cur >= trial) begin
        rem_q[s]  <= rem_cur - trial;
        root_q[s] <= {root_in[ResW-2:0], 1'b1};
      end else begin
        rem_q[s]  <= rem_cur;
        root_q[s] <= {root_in[ResW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[ResW-1];
  assign root_o  = root_q[ResW-1];
  assign rem_o   = rem_q[ResW-1][ResW+1:0];
  assign side_o  = side_q[ResW-1];

endmodule

### hw/rtl/periodic_bond_angle_core.sv
// ----------------------------------------------------------------------------
// periodic_bond_angle_core: minimum-image bond lengths and bond angle
// Streams atom triples; returns both bond lengths and the angle between them.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  direction  accepted when
//  -------   ---------------------------------------  ---------  ------------------
//  item in   start, busy, centre_*_i, first_*_i,       in         start && !busy
//            second_*_i
//  result    result_valid_o, angle_deg_o, *_len_o,     out        result_valid_o
//            *_found_o                                            (one cycle only)
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,    in         cfg_valid_i &&
//            cfg_data_i                                           cfg_ready_o
//
// Fully pipelined: one item per cycle, every cycle. The pipeline depth
// is mostly set by the two square root pipelines (24 and 32 bit stages)
// and the 18 CORDIC stages. busy stays low and cfg_ready_o stays high.
// Reset clears the valid bits and loads the register defaults. The
// receiver cannot stall, so nothing holds.
//
// Pipeline outline:
//   a  displacement bonded - centre
//   b  three images per axis, magnitude and range check
//   c  per-axis squares
//   d  27 squared lengths per bond against the limit
//   e  first qualifying image (x-major priority)
//   .. bond length roots (24 stages)
//   f  round to nearest, saturate
//   g  component magnitudes and maximum
//   h  normalise to [2^14, 2^15)
//   i  3x3 component products
//   j  cross product and dot product
//   k  squared cross components
//   l  sum of squares
//   .. cross magnitude root (32 stages)
//   m  quadrant turn for negative dot
//   .. 18 vectoring CORDIC stages
//   o  clamp and output register
// ----------------------------------------------------------------------------
module periodic_bond_angle_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          centre_x_i,
  input  logic signed [31:0]          centre_y_i,
  input  logic signed [31:0]          centre_z_i,
  input  logic signed [31:0]          first_x_i,
  input  logic signed [31:0]          first_y_i,
  input  logic signed [31:0]          first_z_i,
  input  logic signed [31:0]          second_x_i,
  input  logic signed [31:0]          second_y_i,
  input  logic signed [31:0]          second_z_i,

  output logic                        result_valid_o,
  output logic [23:0]                 angle_deg_o,
  output logic [17:0]                 first_len_o,
  output logic [17:0]                 second_len_o,
  output logic                        first_found_o,
  output logic                        second_found_o,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pba_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  localparam int unsigned Steps = pba_pkg::CordicSteps;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] box_q;
  logic [31:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= pba_pkg::BOX_RESET;
      lim_q <= pba_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pba_pkg::REG_BOX_LENGTH:    box_q <= cfg_data_i;
        pba_pkg::REG_BOND_SQ_LIMIT: lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage a: displacements (33 bit, exact)
  // --------------------------------------------------------------------------
  logic               a_vld_q;
  logic signed [32:0] a_d_q [2][3];
  logic signed [31:0] ctr   [3];
  logic signed [31:0] atom  [2][3];

  always_comb begin
    ctr[0]     = centre_x_i;
    ctr[1]     = centre_y_i;
    ctr[2]     = centre_z_i;
    atom[0][0] = first_x_i;
    atom[0][1] = first_y_i;
    atom[0][2] = first_z_i;
    atom[1][0] = second_x_i;
    atom[1][1] = second_y_i;
    atom[1][2] = second_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) begin
        a_d_q[b][a] <= 33'(atom[b][a]) - 33'(ctr[a]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage b: images -box, 0, +box per axis
  // --------------------------------------------------------------------------
  logic               b_vld_q;
  logic [24:0]        b_mag_d [2][3][3];
  logic [24:0]        b_mag_q [2][3][3];
  logic               b_ok_d  [2][3][3];
  logic               b_ok_q  [2][3][3];
  logic signed [25:0] b_c_d   [2][3][3];
  logic signed [25:0] b_c_q   [2][3][3];

  always_comb begin
    logic signed [34:0] box_s;
    logic signed [34:0] dext;
    logic signed [34:0] cc;
    logic signed [34:0] mm;
    box_s = $signed({3'b000, box_q});
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) begin
        dext = 35'(a_d_q[b][a]);
        for (int i = 0; i < 3; i++) begin
          if (i == 0) begin
            cc = dext - box_s;
          end else if (i == 1) begin
            cc = dext;
          end else begin
            cc = dext + box_s;
          end
          mm               = cc[34] ? -cc : cc;
          b_mag_d[b][a][i] = mm[24:0];
          b_ok_d[b][a][i]  = (mm[34:25] == '0);   // magnitude below 2^25
          b_c_d[b][a][i]   = cc[25:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_mag_q <= b_mag_d;
    b_ok_q  <= b_ok_d;
    b_c_q   <= b_c_d;
  end

  // --------------------------------------------------------------------------
  // Stage c: per-axis squares
  // --------------------------------------------------------------------------
  logic               c_vld_q;
  logic [49:0]        c_sq_q [2][3][3];
  logic               c_ok_q [2][3][3];
  logic signed [25:0] c_c_q  [2][3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          c_sq_q[b][a][i] <= {25'd0, b_mag_q[b][a][i]} * {25'd0, b_mag_q[b][a][i]};
        end
      end
    end
    c_ok_q <= b_ok_q;
    c_c_q  <= b_c_q;
  end

  // --------------------------------------------------------------------------
  // Stage d: 27 squared lengths per bond, compared with limit * 2^16
  // --------------------------------------------------------------------------
  logic               d_vld_q;
  logic               d_hit_d [2][27];
  logic               d_hit_q [2][27];
  logic [47:0]        d_s_d   [2][27];
  logic [47:0]        d_s_q   [2][27];
  logic signed [25:0] d_c_q   [2][3][3];

  always_comb begin
    logic [51:0] sum;
    logic [51:0] lim_ext;
    lim_ext = {4'd0, lim_q, 16'd0};
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            sum = {2'b00, c_sq_q[b][0][i]} + {2'b00, c_sq_q[b][1][j]}
                + {2'b00, c_sq_q[b][2][k]};
            d_hit_d[b][i*9+j*3+k] = c_ok_q[b][0][i] && c_ok_q[b][1][j]
                                 && c_ok_q[b][2][k] && (sum < lim_ext);
            d_s_d[b][i*9+j*3+k]   = sum[47:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_hit_q <= d_hit_d;
    d_s_q   <= d_s_d;
    d_c_q   <= c_c_q;
  end

  // --------------------------------------------------------------------------
  // Stage e: first qualifying image, ix outermost
  // --------------------------------------------------------------------------
  logic               e_vld_q;
  logic               e_found_d [2];
  logic               e_found_q [2];
  logic [47:0]        e_sq_d    [2];
  logic [47:0]        e_sq_q    [2];
  logic [2:0][25:0]   e_vec_d   [2];
  logic [2:0][25:0]   e_vec_q   [2];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      e_found_d[b] = 1'b0;
      e_sq_d[b]    = '0;
      e_vec_d[b]   = '0;
      // walk backwards so the earliest hit wins
      for (int i = 2; i >= 0; i--) begin
        for (int j = 2; j >= 0; j--) begin
          for (int k = 2; k >= 0; k--) begin
            if (d_hit_q[b][i*9+j*3+k]) begin
              e_found_d[b]  = 1'b1;
              e_sq_d[b]     = d_s_q[b][i*9+j*3+k];
              e_vec_d[b][0] = d_c_q[b][0][i];
              e_vec_d[b][1] = d_c_q[b][1][j];
              e_vec_d[b][2] = d_c_q[b][2][k];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_found_q <= e_found_d;
    e_sq_q    <= e_sq_d;
    e_vec_q   <= e_vec_d;
  end

  // --------------------------------------------------------------------------
  // Bond length roots
  // --------------------------------------------------------------------------
  pba_pkg::len_side_t len_side_in;
  pba_pkg::len_side_t len_side_out;
  logic               len1_vld;
  logic               len2_vld;
  logic [23:0]        len1_root;
  logic [23:0]        len2_root;
  logic [25:0]        len1_rem;
  logic [25:0]        len2_rem;
  logic               len2_found;

  assign len_side_in.first_found = e_found_q[0];
  assign len_side_in.first_vec   = e_vec_q[0];
  assign len_side_in.second_vec  = e_vec_q[1];

  pba_isqrt #(
    .RAD_W  (48),
    .SIDE_W ($bits(pba_pkg::len_side_t))
  ) u_len1_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_vld_q),
    .rad_i   (e_sq_q[0]),
    .side_i  (len_side_in),
    .valid_o (len1_vld),
    .root_o  (len1_root),
    .rem_o   (len1_rem),
    .side_o  (len_side_out)
  );

  pba_isqrt #(
    .RAD_W  (48),
    .SIDE_W (1)
  ) u_len2_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_vld_q),
    .rad_i   (e_sq_q[1]),
    .side_i  (e_found_q[1]),
    .valid_o (len2_vld),
    .root_o  (len2_root),
    .rem_o   (len2_rem),
    .side_o  (len2_found)
  );

  // --------------------------------------------------------------------------
  // Stage f: round to nearest (remainder above root), saturate at 2.0
  // --------------------------------------------------------------------------
  logic             f_vld_q;
  logic [17:0]      f_len_q   [2];
  logic             f_found_q [2];
  logic [2:0][25:0] f_vec_q   [2];
  logic [24:0]      rnd1;
  logic [24:0]      rnd2;

  assign rnd1 = {1'b0, len1_root} + 25'({2'b00, len1_root} < len1_rem);
  assign rnd2 = {1'b0, len2_root} + 25'({2'b00, len2_root} < len2_rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= len1_vld && len2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    f_found_q[0] <= len_side_out.first_found;
    f_found_q[1] <= len2_found;
    f_vec_q[0]   <= len_side_out.first_vec;
    f_vec_q[1]   <= len_side_out.second_vec;
    if (!len_side_out.first_found) begin
      f_len_q[0] <= '0;
    end else if (rnd1 > 25'(pba_pkg::LEN_SAT)) begin
      f_len_q[0] <= pba_pkg::LEN_SAT;
    end else begin
      f_len_q[0] <= rnd1[17:0];
    end
    if (!len2_found) begin
      f_len_q[1] <= '0;
    end else if (rnd2 > 25'(pba_pkg::LEN_SAT)) begin
      f_len_q[1] <= pba_pkg::LEN_SAT;
    end else begin
      f_len_q[1] <= rnd2[17:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage g: magnitudes and largest magnitude per vector
  // --------------------------------------------------------------------------
  logic        g_vld_q;
  logic [24:0] g_mag_d [2][3];
  logic [24:0] g_mag_q [2][3];
  logic        g_neg_d [2][3];
  logic        g_neg_q [2][3];
  logic [24:0] g_max_d [2];
  logic [24:0] g_max_q [2];
  logic [17:0] g_len_q   [2];
  logic        g_found_q [2];

  always_comb begin
    logic signed [25:0] comp;
    logic signed [25:0] cabs;
    for (int b = 0; b < 2; b++) begin
      g_max_d[b] = '0;
      for (int a = 0; a < 3; a++) begin
        comp          = $signed(f_vec_q[b][a]);
        cabs          = comp[25] ? -comp : comp;
        g_neg_d[b][a] = comp[25];
        g_mag_d[b][a] = cabs[24:0];
        if (cabs[24:0] > g_max_d[b]) begin
          g_max_d[b] = cabs[24:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_mag_q   <= g_mag_d;
    g_neg_q   <= g_neg_d;
    g_max_q   <= g_max_d;
    g_len_q   <= f_len_q;
    g_found_q <= f_found_q;
  end

  // --------------------------------------------------------------------------
  // Stage h: shift so the largest magnitude lies in [2^14, 2^15);
  // shrinking truncates toward zero (shift magnitude, then restore sign)
  // --------------------------------------------------------------------------
  logic               h_vld_q;
  logic signed [15:0] h_p_d [2][3];
  logic signed [15:0] h_p_q [2][3];
  logic               h_zero [2];
  pba_pkg::res_side_t h_res_q;

  always_comb begin
    logic [4:0]  msb;
    logic [24:0] nm;
    logic [15:0] nm16;
    for (int b = 0; b < 2; b++) begin
      msb = '0;
      for (int t = 0; t < 25; t++) begin
        if (g_max_q[b][t]) begin
          msb = 5'(t);
        end
      end
      h_zero[b] = (g_max_q[b] == '0);
      for (int a = 0; a < 3; a++) begin
        if (msb < 5'd14) begin
          nm = g_mag_q[b][a] << (5'd14 - msb);
        end else begin
          nm = g_mag_q[b][a] >> (msb - 5'd14);
        end
        nm16        = {1'b0, nm[14:0]};
        h_p_d[b][a] = g_neg_q[b][a] ? -$signed(nm16) : $signed(nm16);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_p_q                <= h_p_d;
    h_res_q.kill         <= !(g_found_q[0] && g_found_q[1]) || h_zero[0] || h_zero[1];
    h_res_q.first_len    <= g_len_q[0];
    h_res_q.second_len   <= g_len_q[1];
    h_res_q.first_found  <= g_found_q[0];
    h_res_q.second_found <= g_found_q[1];
  end

  // --------------------------------------------------------------------------
  // Stage i: all nine component products p[a] * q[c]
  // --------------------------------------------------------------------------
  logic               i_vld_q;
  logic signed [31:0] i_prod_q [3][3];
  pba_pkg::res_side_t i_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_vld_q <= 1'b0;
    end else begin
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        i_prod_q[a][c] <= h_p_q[0][a] * h_p_q[1][c];
      end
    end
    i_res_q <= h_res_q;
  end

  // --------------------------------------------------------------------------
  // Stage j: cross and dot products
  // --------------------------------------------------------------------------
  logic               j_vld_q;
  logic signed [32:0] j_cross_q [3];
  logic signed [33:0] j_dot_q;
  pba_pkg::res_side_t j_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_vld_q <= 1'b0;
    end else begin
      j_vld_q <= i_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    j_cross_q[0] <= 33'(i_prod_q[1][2]) - 33'(i_prod_q[2][1]);
    j_cross_q[1] <= 33'(i_prod_q[2][0]) - 33'(i_prod_q[0][2]);
    j_cross_q[2] <= 33'(i_prod_q[0][1]) - 33'(i_prod_q[1][0]);
    j_dot_q      <= 34'(i_prod_q[0][0]) + 34'(i_prod_q[1][1]) + 34'(i_prod_q[2][2]);
    j_res_q      <= i_res_q;
  end

  // --------------------------------------------------------------------------
  // Stage k: squared cross components
  // --------------------------------------------------------------------------
  logic               k_vld_q;
  logic [63:0]        k_csq_q [3];
  logic signed [33:0] k_dot_q;
  pba_pkg::res_side_t k_res_q;
  logic [31:0]        k_abs   [3];

  always_comb begin
    logic signed [32:0] t;
    for (int a = 0; a < 3; a++) begin
      t        = j_cross_q[a][32] ? -j_cross_q[a] : j_cross_q[a];
      k_abs[a] = t[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_vld_q <= 1'b0;
    end else begin
      k_vld_q <= j_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      k_csq_q[a] <= {32'd0, k_abs[a]} * {32'd0, k_abs[a]};
    end
    k_dot_q <= j_dot_q;
    k_res_q <= j_res_q;
  end

  // --------------------------------------------------------------------------
  // Stage l: |c|^2 (below 9 * 2^60, fits 64 bits)
  // --------------------------------------------------------------------------
  logic               l_vld_q;
  logic [63:0]        l_cs_q;
  pba_pkg::ang_side_t l_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_vld_q <= 1'b0;
    end else begin
      l_vld_q <= k_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l_cs_q       <= k_csq_q[0] + k_csq_q[1] + k_csq_q[2];
    l_side_q.dot <= k_dot_q;
    l_side_q.res <= k_res_q;
  end

  // --------------------------------------------------------------------------
  // Cross magnitude root
  // --------------------------------------------------------------------------
  logic               cr_vld;
  logic [31:0]        cr_root;
  pba_pkg::ang_side_t cr_side;

  pba_isqrt #(
    .RAD_W  (64),
    .SIDE_W ($bits(pba_pkg::ang_side_t))
  ) u_cross_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (l_vld_q),
    .rad_i   (l_cs_q),
    .side_i  (l_side_q),
    .valid_o (cr_vld),
    .root_o  (cr_root),
    .rem_o   (),
    .side_o  (cr_side)
  );

  // --------------------------------------------------------------------------
  // Stage m and CORDIC: atan2(|c|, dot) in Q16 degrees.
  // Index 0 holds the turned start vector; index s+1 the result of step s.
  // --------------------------------------------------------------------------
  logic               cd_vld_q [Steps+1];
  logic signed [35:0] cd_x_q   [Steps+1];
  logic signed [35:0] cd_y_q   [Steps+1];
  logic signed [25:0] cd_z_q   [Steps+1];
  pba_pkg::res_side_t cd_res_q [Steps+1];

  logic signed [35:0] m_x0;
  logic signed [35:0] m_y0;

  assign m_x0 = 36'(cr_side.dot);
  assign m_y0 = $signed({4'd0, cr_root});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_vld_q[0] <= 1'b0;
    end else begin
      cd_vld_q[0] <= cr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    cd_res_q[0] <= cr_side.res;
    if (m_x0 < 0) begin
      // negative dot: start a quarter turn on
      cd_x_q[0] <= m_y0;
      cd_y_q[0] <= -m_x0;
      cd_z_q[0] <= $signed(pba_pkg::ROT90);
    end else begin
      cd_x_q[0] <= m_x0;
      cd_y_q[0] <= m_y0;
      cd_z_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_cordic
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic signed [25:0] at;

    assign xs = cd_x_q[s] >>> s;   // floor shift
    assign ys = cd_y_q[s] >>> s;
    assign at = $signed({4'd0, pba_pkg::atan_deg(s)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cd_vld_q[s+1] <= 1'b0;
      end else begin
        cd_vld_q[s+1] <= cd_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      cd_res_q[s+1] <= cd_res_q[s];
      if (cd_y_q[s] > 0) begin
        cd_x_q[s+1] <= cd_x_q[s] + ys;
        cd_y_q[s+1] <= cd_y_q[s] - xs;
        cd_z_q[s+1] <= cd_z_q[s] + at;
      end else begin
        cd_x_q[s+1] <= cd_x_q[s] - ys;
        cd_y_q[s+1] <= cd_y_q[s] + xs;
        cd_z_q[s+1] <= cd_z_q[s] - at;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage o: clamp to [0, 180 deg], zero angle for a missing or zero bond
  // --------------------------------------------------------------------------
  logic signed [25:0] z_fin;
  pba_pkg::res_side_t res_fin;

  assign z_fin   = cd_z_q[Steps];
  assign res_fin = cd_res_q[Steps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cd_vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    first_len_o    <= res_fin.first_len;
    second_len_o   <= res_fin.second_len;
    first_found_o  <= res_fin.first_found;
    second_found_o <= res_fin.second_found;
    if (res_fin.kill || z_fin < 0) begin
      angle_deg_o <= '0;
    end else if (z_fin > $signed(26'(pba_pkg::ANGLE_MAX))) begin
      angle_deg_o <= pba_pkg::ANGLE_MAX;
    end else begin
      angle_deg_o <= z_fin[23:0];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_angle_needs_both : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (!first_found_o || !second_found_o) |-> angle_deg_o == '0)
    else $error("angle reported for a missing bond");

  a_missing_len_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !first_found_o |-> first_len_o == '0 && $past(res_fin.kill))
    else $error("missing first bond has a length or the angle was not killed");

  a_len_saturated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> first_len_o <= pba_pkg::LEN_SAT
                     && second_len_o <= pba_pkg::LEN_SAT
                     && angle_deg_o <= pba_pkg::ANGLE_MAX)
    else $error("result field beyond its range");

  a_pipe_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_vld_q |-> $past(len1_vld) && $past(len2_vld))
    else $error("length root pipelines out of step");

endmodule
